// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the ranger RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== src/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, constants and codes of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

   localparam int CHANNELS = 8;
   localparam int SLOTS    = 8;
   localparam int ACTIVE   = (CHANNELS < SLOTS) ? CHANNELS : SLOTS;

   localparam int KIND_W  = 2;
   localparam int CHAN_W  = 3;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 16;
   localparam int SEC_W   = 16;
   localparam int BASE_W  = 11;
   localparam int ID_W    = 12;
   localparam int DIST_W  = 14;
   localparam int RATE_W  = 8;
   localparam int TRIG_W  = 8;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   // distance = floor(width * 17 / 100), divide by reciprocal and one correction
   localparam int PROD_W      = 21;
   localparam int RECIP_W     = 18;
   localparam int MULT_W      = PROD_W + RECIP_W;
   localparam int RECIP_SHIFT = 24;

   localparam logic [PROD_W-1:0]  SCALE     = PROD_W'(17);
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((1 << RECIP_SHIFT) / 100);
   localparam logic [PROD_W-1:0]  DIVISOR   = PROD_W'(100);
   localparam logic [PROD_W-1:0]  REM_LIMIT = PROD_W'(200);

   localparam logic [TRIG_W-1:0] TRIG_ALL  = TRIG_W'((1 << ACTIVE) - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ACTIVE - 1);
   localparam logic [SEC_W-1:0]  SEC_RESET = '1;

   localparam logic [KIND_W-1:0] KIND_ECHO     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PERIOD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TRIG_END = 2'd2;

   localparam logic REG_BASE_ID = 1'b0;

   typedef struct packed {
      logic rise_store;
      logic fall_update;
      logic period_update;
      logic trig_end;
      logic slot_next;
      logic emit_dist;
      logic emit_status;
   } uer_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              level;
      logic              active;
      logic              last_slot;
      logic              out_free;
   } uer_stat_type;

   function automatic logic chan_active(input logic [CHAN_W-1:0] ch);
      return int'(ch) < ACTIVE;
   endfunction

endpackage

`default_nettype wire

// ===== src/uer_if.sv =====
// ----------------------------------------------------------------------------
// uer_if
// Valid/ready word channels of the ranger: event requests and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface uer_req_if;
   logic                        valid;
   logic                        ready;
   logic [uer_pkg::KIND_W-1:0]  kind;
   logic [uer_pkg::CHAN_W-1:0]  channel;
   logic                        level;
   logic [uer_pkg::COUNT_W-1:0] count;
   logic [uer_pkg::SEC_W-1:0]   now_second;

   modport source (output valid, kind, channel, level, count, now_second, input ready);
   modport sink (input valid, kind, channel, level, count, now_second, output ready);
endinterface

interface uer_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       report;
   logic [uer_pkg::ID_W-1:0]   message_id;
   logic [uer_pkg::DIST_W-1:0] distance;
   logic [uer_pkg::TRIG_W-1:0] trigger_lines;
   logic [uer_pkg::RATE_W-1:0] rate;
   logic                       last;

   modport source (output valid, report, message_id, distance, trigger_lines, rate, last,
                   input ready);
   modport sink (input valid, report, message_id, distance, trigger_lines, rate, last,
                 output ready);
endinterface

`default_nettype wire

// ===== src/uer_datapath.sv =====
// ----------------------------------------------------------------------------
// uer_datapath
// Channel edge store, width update, distance pipeline, rate tally and the
// result word register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uer_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [uer_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [uer_pkg::CHAN_W-1:0]  req_channel,
   input  wire logic                        req_level,
   input  wire logic [uer_pkg::COUNT_W-1:0] req_count,
   input  wire logic [uer_pkg::SEC_W-1:0]   req_now_second,
   input  wire logic                        base_we,
   input  wire logic [uer_pkg::BASE_W-1:0]  base_wdata,
   output logic      [uer_pkg::BASE_W-1:0]  base_id,
   input  wire uer_pkg::uer_cmd_type        cmd,
   output uer_pkg::uer_stat_type            stat,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_report,
   output logic      [uer_pkg::ID_W-1:0]    rsp_message_id,
   output logic      [uer_pkg::DIST_W-1:0]  rsp_distance,
   output logic      [uer_pkg::TRIG_W-1:0]  rsp_trigger_lines,
   output logic      [uer_pkg::RATE_W-1:0]  rsp_rate,
   output logic                             rsp_last
);

   // item held for the duration of its work
   logic [uer_pkg::KIND_W-1:0]  kind_ff;
   logic [uer_pkg::CHAN_W-1:0]  chan_ff;
   logic                        level_ff;
   logic [uer_pkg::COUNT_W-1:0] count_ff;
   logic [uer_pkg::SEC_W-1:0]   sec_ff;
   logic [uer_pkg::SLOT_W-1:0]  slot_ff, slot_in;

   // per-channel state
   logic [uer_pkg::COUNT_W-1:0] rise_time_ff [uer_pkg::SLOTS];
   logic [uer_pkg::COUNT_W-1:0] width_ff     [uer_pkg::SLOTS];
   logic [uer_pkg::SLOTS-1:0]   seen_ff, seen_in;
   logic [uer_pkg::COUNT_W-1:0] rise_sel, width_sel, width_new;

   // global state
   logic [uer_pkg::BASE_W-1:0] base_ff, base_in;
   logic [uer_pkg::TRIG_W-1:0] trig_ff, trig_in;
   logic [uer_pkg::SEC_W-1:0]  stored_sec_ff, stored_sec_in;
   logic [uer_pkg::RATE_W-1:0] last_rate_ff, last_rate_in;
   logic [uer_pkg::RATE_W-1:0] tally_ff, tally_in;

   // distance pipeline
   logic [uer_pkg::COUNT_W-1:0] w_ff;
   logic [uer_pkg::PROD_W-1:0]  p_ff, p2_ff;
   logic [uer_pkg::DIST_W-1:0]  q0_ff;
   logic [uer_pkg::MULT_W-1:0]  mult;
   logic [uer_pkg::PROD_W-1:0]  rem_raw;
   logic [uer_pkg::DIST_W-1:0]  dist_fix;

   // result word register
   logic                       out_valid_ff, out_valid_in;
   logic                       out_report_ff;
   logic [uer_pkg::ID_W-1:0]   out_id_ff;
   logic [uer_pkg::DIST_W-1:0] out_dist_ff;
   logic [uer_pkg::TRIG_W-1:0] out_trig_ff;
   logic [uer_pkg::RATE_W-1:0] out_rate_ff;
   logic                       out_last_ff;
   logic                       out_free, out_load;
   logic [uer_pkg::RATE_W-1:0] rate_now;

   assign rise_sel  = rise_time_ff[slot_ff];
   assign width_sel = width_ff[slot_ff];

   always_comb begin
      if (!seen_ff[slot_ff]) begin
         width_new = '0;
      end else if (rise_sel < count_ff) begin
         width_new = count_ff - rise_sel;
      end else begin
         width_new = width_sel;
      end
   end

   always_comb begin
      if (accept) begin
         slot_in = (req_kind == uer_pkg::KIND_ECHO) ? uer_pkg::SLOT_W'(req_channel) : '0;
      end else if (cmd.slot_next) begin
         slot_in = slot_ff + uer_pkg::SLOT_W'(1);
      end else begin
         slot_in = slot_ff;
      end
   end

   always_comb begin
      seen_in       = seen_ff;
      trig_in       = trig_ff;
      stored_sec_in = stored_sec_ff;
      last_rate_in  = last_rate_ff;
      tally_in      = tally_ff;
      base_in       = base_we ? base_wdata : base_ff;
      if (cmd.rise_store) begin
         seen_in[slot_ff] = 1'b1;
      end
      if (cmd.period_update) begin
         seen_in = '0;
         trig_in = uer_pkg::TRIG_ALL;
         if (stored_sec_ff != sec_ff) begin
            stored_sec_in = sec_ff;
            last_rate_in  = tally_ff;
            tally_in      = uer_pkg::RATE_W'(1);
         end else begin
            tally_in = tally_ff + uer_pkg::RATE_W'(1);
         end
      end
      if (cmd.trig_end) begin
         seen_in = '0;
         trig_in = '0;
      end
   end

   assign mult     = p_ff * uer_pkg::RECIP;
   assign rem_raw  = p2_ff - uer_pkg::PROD_W'(q0_ff) * uer_pkg::DIVISOR;
   assign dist_fix = (rem_raw >= uer_pkg::DIVISOR) ? q0_ff + uer_pkg::DIST_W'(1) : q0_ff;
   assign rate_now = (stored_sec_ff == sec_ff) ? last_rate_ff : '0;

   assign out_free     = !out_valid_ff || rsp_ready;
   assign out_load     = cmd.emit_dist || cmd.emit_status;
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= '0;
         trig_ff       <= '0;
         stored_sec_ff <= uer_pkg::SEC_RESET;
         last_rate_ff  <= '0;
         tally_ff      <= '0;
         base_ff       <= '0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < uer_pkg::SLOTS; i++) begin
            width_ff[i] <= '0;
         end
      end else begin
         seen_ff       <= seen_in;
         trig_ff       <= trig_in;
         stored_sec_ff <= stored_sec_in;
         last_rate_ff  <= last_rate_in;
         tally_ff      <= tally_in;
         base_ff       <= base_in;
         out_valid_ff  <= out_valid_in;
         if (cmd.fall_update) begin
            width_ff[slot_ff] <= width_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (accept) begin
         kind_ff  <= req_kind;
         chan_ff  <= req_channel;
         level_ff <= req_level;
         count_ff <= req_count;
         sec_ff   <= req_now_second;
      end
      if (cmd.rise_store) begin
         rise_time_ff[slot_ff] <= count_ff;
      end
      w_ff  <= width_sel;
      p_ff  <= uer_pkg::PROD_W'(w_ff) * uer_pkg::SCALE;
      p2_ff <= p_ff;
      q0_ff <= mult[uer_pkg::RECIP_SHIFT +: uer_pkg::DIST_W];
      if (out_load) begin
         out_report_ff <= cmd.emit_status;
         out_id_ff     <= cmd.emit_dist ?
                          uer_pkg::ID_W'(base_ff) + uer_pkg::ID_W'(slot_ff) : '0;
         out_dist_ff   <= cmd.emit_dist ? dist_fix : '0;
         out_trig_ff   <= trig_ff;
         out_rate_ff   <= rate_now;
         out_last_ff   <= cmd.emit_status || (kind_ff == uer_pkg::KIND_ECHO) ||
                          (slot_ff == uer_pkg::LAST_SLOT);
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.level     = level_ff;
   assign stat.active    = uer_pkg::chan_active(chan_ff);
   assign stat.last_slot = (slot_ff == uer_pkg::LAST_SLOT);
   assign stat.out_free  = out_free;

   assign base_id           = base_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_report        = out_report_ff;
   assign rsp_message_id    = out_id_ff;
   assign rsp_distance      = out_dist_ff;
   assign rsp_trigger_lines = out_trig_ff;
   assign rsp_rate          = out_rate_ff;
   assign rsp_last          = out_last_ff;

   `ASSERT_PROP(a_recip_within_one, clock, reset, cmd.emit_dist |-> rem_raw < uer_pkg::REM_LIMIT)
   `ASSERT_NEVER(a_no_overwrite, clock, reset, out_load && !out_free)
   `ASSERT_PROP(a_trig_drop, clock, reset, cmd.trig_end |=> trig_ff == '0)

endmodule

`default_nettype wire

// ===== src/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// uer_ctrl
// Sequencer: decodes each accepted event word and steps the datapath through
// its updates and result words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module uer_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire uer_pkg::uer_stat_type stat,
   output uer_pkg::uer_cmd_type       cmd,
   output logic                       ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_EMIT,
      ST_STATUS
   } state_type;

   localparam logic [1:0] FILL_LAST = 2'd2;

   state_type  state_ff, state_in;
   logic [1:0] fill_ff, fill_in;
   logic       ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      fill_in  = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            fill_in = '0;
            case (stat.kind)
               uer_pkg::KIND_ECHO: begin
                  if (!stat.active) begin
                     state_in = ST_IDLE;
                  end else if (stat.level) begin
                     cmd.rise_store = 1'b1;
                     state_in       = ST_IDLE;
                  end else begin
                     cmd.fall_update = 1'b1;
                     state_in        = ST_FILL;
                  end
               end
               uer_pkg::KIND_PERIOD: begin
                  cmd.period_update = 1'b1;
                  state_in          = ST_FILL;
               end
               uer_pkg::KIND_TRIG_END: begin
                  cmd.trig_end = 1'b1;
                  state_in     = ST_STATUS;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FILL: begin
            fill_in = fill_ff + 2'd1;
            if (fill_ff == FILL_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_dist = 1'b1;
               if ((stat.kind == uer_pkg::KIND_ECHO) || stat.last_slot) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.slot_next = 1'b1;
                  fill_in       = '0;
                  state_in      = ST_FILL;
               end
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ready_in = (state_in == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ready_ff <= ready_in;
      end
   end

   assign ready = ready_ff;

   `ASSERT_PROP(a_accept_decode, clock, reset, accept |=> state_ff == ST_DECODE)
   `ASSERT_PROP(a_ready_idle, clock, reset, ready_ff |-> state_ff == ST_IDLE)
   `ASSERT_PROP(a_one_update, clock, reset, $onehot0({cmd.rise_store, cmd.fall_update, cmd.period_update, cmd.trig_end}))

endmodule

`default_nettype wire

// ===== src/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Multi-channel echo pulse width ranger: edge capture, distance reports,
// trigger lines and per-second sample rate.
//
//   channel   direction  handshake      contents
//   req_bus   in         valid/ready    event word: kind, channel, level, count, second
//   rsp_bus   out        valid/ready    result word: report, id, distance, lines, rate, last
//   csr_*     in         APB write/read base message id at byte address 0
//
// A rising edge, an ignored event or an unknown kind ends in the decode state.
// A falling edge loads a distance word and a trigger end a status word; a period start
// loads one distance word per channel, each after the three-stage width-to-distance
// pipeline has been refilled for that channel in turn.
// The result word register holds while rsp ready is low; the sequencer waits on it.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger (
   input  wire logic                       clock,
   input  wire logic                       reset,
   uer_req_if.sink                         req_bus,
   uer_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [uer_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [uer_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [uer_pkg::DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   uer_pkg::uer_cmd_type       cmd;
   uer_pkg::uer_stat_type      stat;
   logic                       ready;
   logic                       accept;
   logic                       base_we;
   logic [uer_pkg::BASE_W-1:0] base_id;

   assign accept        = req_bus.valid && ready;
   assign req_bus.ready = ready;

   assign csr_pready = 1'b1;
   assign base_we    = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == uer_pkg::REG_BASE_ID);
   assign csr_prdata = (csr_paddr[2] == uer_pkg::REG_BASE_ID) ?
                       uer_pkg::DATA_W'(base_id) : '0;

   uer_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .stat   (stat),
      .cmd    (cmd),
      .ready  (ready)
   );

   uer_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_kind          (req_bus.kind),
      .req_channel       (req_bus.channel),
      .req_level         (req_bus.level),
      .req_count         (req_bus.count),
      .req_now_second    (req_bus.now_second),
      .base_we           (base_we),
      .base_wdata        (csr_pwdata[uer_pkg::BASE_W-1:0]),
      .base_id           (base_id),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_report        (rsp_bus.report),
      .rsp_message_id    (rsp_bus.message_id),
      .rsp_distance      (rsp_bus.distance),
      .rsp_trigger_lines (rsp_bus.trigger_lines),
      .rsp_rate          (rsp_bus.rate),
      .rsp_last          (rsp_bus.last)
   );

endmodule

`default_nettype wire
